/* src/hsvrgb_pkg.sv */
package hsvrgb_pkg;

    localparam int unsigned HUE_PER_SECTOR = 3840;
    localparam int unsigned HUE_LIMIT      = 23040;
    localparam int unsigned FULL_SCALE     = 255;

    // floor(x / 255) for x below 2^16 is exact as (x * LOW_RECIP) >> LOW_SHIFT.
    localparam int unsigned LOW_RECIP = 65794;
    localparam int unsigned LOW_SHIFT = 24;

    // floor(a / 3825) for a below 2^20 is exact as (a * MID_RECIP) >> MID_SHIFT.
    localparam longint unsigned MID_RECIP = 64'd2245735;
    localparam int unsigned     MID_SHIFT = 33;

    typedef enum logic [2:0] {
        SEC_RED_YELLOW    = 3'd0,
        SEC_YELLOW_GREEN  = 3'd1,
        SEC_GREEN_CYAN    = 3'd2,
        SEC_CYAN_BLUE     = 3'd3,
        SEC_BLUE_MAGENTA  = 3'd4,
        SEC_MAGENTA_RED   = 3'd5
    } sector_t;

    typedef struct packed {
        sector_t     sector;
        logic [11:0] ramp;
        logic [15:0] vs;
        logic [15:0] vns;
        logic [7:0]  bright;
    } prep_t;

    typedef struct packed {
        sector_t     sector;
        logic [7:0]  bright;
        logic [7:0]  low;
        logic [19:0] num_hi;
    } scale_t;

    typedef struct packed {
        sector_t    sector;
        logic [7:0] bright;
        logic [7:0] low;
        logic [7:0] mid;
    } mix_t;

    function automatic logic [14:0] sector_base(input sector_t sector);
        logic [14:0] base;
        case (sector)
            SEC_RED_YELLOW:   base = 15'd0;
            SEC_YELLOW_GREEN: base = 15'(HUE_PER_SECTOR);
            SEC_GREEN_CYAN:   base = 15'(2 * HUE_PER_SECTOR);
            SEC_CYAN_BLUE:    base = 15'(3 * HUE_PER_SECTOR);
            SEC_BLUE_MAGENTA: base = 15'(4 * HUE_PER_SECTOR);
            SEC_MAGENTA_RED:  base = 15'(5 * HUE_PER_SECTOR);
            default:          base = 15'(5 * HUE_PER_SECTOR);
        endcase
        return base;
    endfunction

endpackage

/* src/hsvrgb_prep.sv */
module hsvrgb_prep
    import hsvrgb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        valid_in,
    input  logic [14:0] hue,
    input  logic [7:0]  saturation,
    input  logic [7:0]  brightness,
    output logic        valid_out,
    output prep_t       data_out
);

    logic        valid_reg;
    prep_t       data_reg;
    prep_t       data_next;
    logic [14:0] hue_clamped;
    logic [2:0]  sector_count;
    sector_t     sector;
    logic [14:0] offset;
    logic [11:0] offset_low;

    always_comb
    begin
        hue_clamped = (hue > 15'(HUE_LIMIT)) ? 15'(HUE_LIMIT) : hue;
        sector_count = 3'(hue_clamped >= 15'(HUE_PER_SECTOR))
                     + 3'(hue_clamped >= 15'(2 * HUE_PER_SECTOR))
                     + 3'(hue_clamped >= 15'(3 * HUE_PER_SECTOR))
                     + 3'(hue_clamped >= 15'(4 * HUE_PER_SECTOR))
                     + 3'(hue_clamped >= 15'(5 * HUE_PER_SECTOR));
        sector = sector_t'(sector_count);
        offset = hue_clamped - sector_base(sector);
        offset_low = offset[11:0];

        data_next.sector = sector;
        data_next.ramp   = sector_count[0] ? (12'(HUE_PER_SECTOR) - offset_low) : offset_low;
        data_next.vs     = {8'd0, brightness} * {8'd0, saturation};
        data_next.vns    = {8'd0, brightness} * {8'd0, 8'(FULL_SCALE) - saturation};
        data_next.bright = brightness;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

/* src/hsvrgb_scale.sv */
module hsvrgb_scale
    import hsvrgb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   valid_in,
    input  prep_t  data_in,
    output logic   valid_out,
    output mix_t   data_out,
    output logic   low_valid,
    output scale_t low_data
);

    logic        scale_valid_reg;
    scale_t      scale_reg;
    scale_t      scale_next;
    logic        mix_valid_reg;
    mix_t        mix_reg;
    mix_t        mix_next;
    logic [27:0] ramp_prod;
    logic [27:0] grey_part;
    logic [27:0] numerator;
    logic [32:0] low_prod;
    logic [41:0] mid_prod;

    // The blended channel is floor(N / (255 * 3840)); the low byte of N is
    // dropped first, leaving a division by 3825 done with a reciprocal.
    always_comb
    begin
        ramp_prod = 28'(data_in.vs) * 28'(data_in.ramp);
        grey_part = (28'(data_in.vns) << 12) - (28'(data_in.vns) << 8);
        numerator = ramp_prod + grey_part;
        low_prod  = 33'(data_in.vns) * 33'(LOW_RECIP);

        scale_next.sector = data_in.sector;
        scale_next.bright = data_in.bright;
        scale_next.low    = low_prod[LOW_SHIFT +: 8];
        scale_next.num_hi = numerator[27:8];
    end

    always_comb
    begin
        mid_prod = 42'(scale_reg.num_hi) * 42'(MID_RECIP);

        mix_next.sector = scale_reg.sector;
        mix_next.bright = scale_reg.bright;
        mix_next.low    = scale_reg.low;
        mix_next.mid    = mid_prod[MID_SHIFT +: 8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_valid_reg <= 1'b0;
            mix_valid_reg   <= 1'b0;
        end
        else if (en)
        begin
            scale_valid_reg <= valid_in;
            mix_valid_reg   <= scale_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            scale_reg <= scale_next;
            mix_reg   <= mix_next;
        end
    end

    assign valid_out = mix_valid_reg;
    assign data_out  = mix_reg;
    assign low_valid = scale_valid_reg;
    assign low_data  = scale_reg;

endmodule

/* src/hsvrgb_route.sv */
module hsvrgb_route
    import hsvrgb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       valid_in,
    input  mix_t       data_in,
    output logic       valid_out,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue
);

    logic       valid_reg;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;
    logic [7:0] red_next;
    logic [7:0] green_next;
    logic [7:0] blue_next;

    always_comb
    begin
        case (data_in.sector)
            SEC_RED_YELLOW:
            begin
                red_next   = data_in.bright;
                green_next = data_in.mid;
                blue_next  = data_in.low;
            end
            SEC_YELLOW_GREEN:
            begin
                red_next   = data_in.mid;
                green_next = data_in.bright;
                blue_next  = data_in.low;
            end
            SEC_GREEN_CYAN:
            begin
                red_next   = data_in.low;
                green_next = data_in.bright;
                blue_next  = data_in.mid;
            end
            SEC_CYAN_BLUE:
            begin
                red_next   = data_in.low;
                green_next = data_in.mid;
                blue_next  = data_in.bright;
            end
            SEC_BLUE_MAGENTA:
            begin
                red_next   = data_in.mid;
                green_next = data_in.low;
                blue_next  = data_in.bright;
            end
            default:
            begin
                red_next   = data_in.bright;
                green_next = data_in.low;
                blue_next  = data_in.mid;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign valid_out = valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

/* src/hsv_to_rgb_converter_top.sv */
// Channel   Valid         Stall         Payload
// input     pixel_valid   pixel_stall   hue[14:0], saturation[7:0], brightness[7:0]
// output    rgb_valid     rgb_stall     red[7:0], green[7:0], blue[7:0]
//
// One pixel is accepted per cycle while rgb_stall does not hold the pipeline; its result reaches the output
// through the four register stages: sector and products, blend numerator, reciprocal divide,
// and channel ordering into the output register.
// Reset clears only the stage valid bits.
// A stall on the output freezes every stage at once, so pixel_stall follows rgb_stall
// while the output holds a transfer.
module hsv_to_rgb_converter_top
    import hsvrgb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pixel_valid,
    output logic        pixel_stall,
    input  logic [14:0] hue,
    input  logic [7:0]  saturation,
    input  logic [7:0]  brightness,
    output logic        rgb_valid,
    input  logic        rgb_stall,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue
);

    logic   en;
    logic   prep_valid;
    prep_t  prep_data;
    logic   mix_valid;
    mix_t   mix_data;
    logic   low_valid;
    scale_t low_data;

    assign en          = !(rgb_valid && rgb_stall);
    assign pixel_stall = !en;

    hsvrgb_prep u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .valid_in   (pixel_valid),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .valid_out  (prep_valid),
        .data_out   (prep_data)
    );

    hsvrgb_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (prep_valid),
        .data_in   (prep_data),
        .valid_out (mix_valid),
        .data_out  (mix_data),
        .low_valid (low_valid),
        .low_data  (low_data)
    );

    hsvrgb_route u_route (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (mix_valid),
        .data_in   (mix_data),
        .valid_out (rgb_valid),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        prep_valid |-> (prep_data.ramp <= 12'(HUE_PER_SECTOR)))
        else $error("hue ramp exceeds one sector");

    assert property (@(posedge clk) disable iff (!rst_n)
        low_valid |-> (low_data.low <= low_data.bright))
        else $error("minimum channel exceeds brightness");

    assert property (@(posedge clk) disable iff (!rst_n)
        mix_valid |-> (mix_data.mid >= mix_data.low && mix_data.mid <= mix_data.bright))
        else $error("blended channel outside its bounds");

    assert property (@(posedge clk) disable iff (!rst_n)
        (prep_valid && pixel_stall) |=> (prep_valid && $stable(prep_data)))
        else $error("first stage changed during a stall");

endmodule

/* tb/tb_hsv_to_rgb_converter_top.sv */
module tb_hsv_to_rgb_converter_top;
    import hsvrgb_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_rgb_t;

    typedef struct {
        logic [14:0] hue;
        logic [7:0]  sat;
        logic [7:0]  val;
        bit          known;
        pixel_rgb_t  rgb;
    } hsv_row_t;

    localparam int NUM_RANDOM = 1900;
    localparam int MAX_HUE    = 32767;

    logic        clk;
    logic        rst_n;
    logic        pixel_valid;
    logic        pixel_stall;
    logic [14:0] hue;
    logic [7:0]  saturation;
    logic [7:0]  brightness;
    logic        rgb_valid;
    logic        rgb_stall;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;

    pixel_rgb_t rgb_expected[$];
    int         mismatches;
    int         pixels_sent;
    int         pixels_clipped;
    int         transfers_checked;
    bit         tx_burst;
    bit         rx_burst;

    hsv_row_t hsv_rows [19] = '{
        '{15'd0,     8'd255, 8'd255, 1'b1, 24'hFF0000},
        '{15'd3840,  8'd255, 8'd255, 1'b1, 24'hFFFF00},
        '{15'd7680,  8'd255, 8'd255, 1'b1, 24'h00FF00},
        '{15'd11520, 8'd255, 8'd255, 1'b1, 24'h00FFFF},
        '{15'd15360, 8'd255, 8'd255, 1'b1, 24'h0000FF},
        '{15'd19200, 8'd255, 8'd255, 1'b1, 24'hFF00FF},
        '{15'd23040, 8'd255, 8'd255, 1'b1, 24'hFF0000},
        '{15'd32767, 8'd255, 8'd255, 1'b1, 24'hFF0000},
        '{15'd0,     8'd0,   8'd0,   1'b1, 24'h000000},
        '{15'd12345, 8'd0,   8'd200, 1'b1, 24'hC8C8C8},
        '{15'd20000, 8'd255, 8'd0,   1'b1, 24'h000000},
        '{15'd23039, 8'd255, 8'd255, 1'b0, 24'h000000},
        '{15'd1920,  8'd128, 8'd200, 1'b0, 24'h000000},
        '{15'd3839,  8'd255, 8'd255, 1'b0, 24'h000000},
        '{15'd3841,  8'd1,   8'd254, 1'b0, 24'h000000},
        '{15'd16383, 8'd170, 8'd85,  1'b0, 24'h000000},
        '{15'd16384, 8'd85,  8'd170, 1'b0, 24'h000000},
        '{15'd23041, 8'd200, 8'd100, 1'b0, 24'h000000},
        '{15'd21845, 8'd254, 8'd1,   1'b0, 24'h000000}
    };

    hsv_to_rgb_converter_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .hue         (hue),
        .saturation  (saturation),
        .brightness  (brightness),
        .rgb_valid   (rgb_valid),
        .rgb_stall   (rgb_stall),
        .red         (red),
        .green       (green),
        .blue        (blue)
    );

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic pixel_rgb_t predict_rgb(input logic [14:0] h, input logic [7:0] s,
                                               input logic [7:0] v);
        int unsigned hh;
        int unsigned sv;
        int unsigned vv;
        int unsigned sec;
        int unsigned ramp;
        int unsigned lo;
        int unsigned mid;
        sector_t     sector;
        pixel_rgb_t  px;
        hh = h;
        sv = s;
        vv = v;
        if (hh > HUE_LIMIT)
            hh = HUE_LIMIT;
        sec = hh / HUE_PER_SECTOR;
        if (sec > 5)
            sec = 5;
        sector = sector_t'(sec);
        ramp = hh - sec * HUE_PER_SECTOR;
        if (sec % 2 == 1)
            ramp = HUE_PER_SECTOR - ramp;
        lo  = (vv * (FULL_SCALE - sv)) / FULL_SCALE;
        mid = (vv * sv * ramp + vv * (FULL_SCALE - sv) * HUE_PER_SECTOR)
              / (FULL_SCALE * HUE_PER_SECTOR);
        case (sector)
            SEC_RED_YELLOW:   px = '{v, mid[7:0], lo[7:0]};
            SEC_YELLOW_GREEN: px = '{mid[7:0], v, lo[7:0]};
            SEC_GREEN_CYAN:   px = '{lo[7:0], v, mid[7:0]};
            SEC_CYAN_BLUE:    px = '{lo[7:0], mid[7:0], v};
            SEC_BLUE_MAGENTA: px = '{mid[7:0], lo[7:0], v};
            default:          px = '{v, lo[7:0], mid[7:0]};
        endcase
        return px;
    endfunction

    function automatic logic [7:0] pick_fraction();
        int unsigned k;
        k = $urandom_range(0, 7);
        if (k == 0)
            return 8'd0;
        if (k == 1)
            return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [14:0] pick_hue();
        int unsigned k;
        int          h;
        k = $urandom_range(0, 9);
        if (k == 0)
            h = $urandom_range(HUE_LIMIT, MAX_HUE);
        else if (k <= 2)
            h = $urandom_range(0, 6) * HUE_PER_SECTOR + $urandom_range(0, 4) - 2;
        else
            h = $urandom_range(0, HUE_LIMIT - 1);
        if (h < 0)
            h = 0;
        return 15'(h);
    endfunction

    // Called just after a rising edge; returns just after the edge that took the transfer.
    task automatic send_pixel(input logic [14:0] h, input logic [7:0] s, input logic [7:0] v,
                              input bit known, input pixel_rgb_t typed);
        int unsigned gap;
        if ($urandom_range(0, 99) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        hue         <= h;
        saturation  <= s;
        brightness  <= v;
        do
            @(negedge clk);
        while (pixel_stall !== 1'b0);
        @(posedge clk);
        rgb_expected.push_back(known ? typed : predict_rgb(h, s, v));
        pixels_sent++;
        if (h > HUE_LIMIT)
            pixels_clipped++;
    endtask

    task automatic check_channel(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic drain_results();
        pixel_valid <= 1'b0;
        wait (rgb_expected.size() == 0);
        @(posedge clk);
    endtask

    initial
    begin
        int unsigned stall_left;
        bit          took;
        pixel_rgb_t  want;
        rgb_stall  <= 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            took = (rgb_valid === 1'b1) && (rgb_stall == 1'b0);
            if (took)
            begin
                if (rgb_expected.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: transfer with nothing expected, actual %0d %0d %0d",
                             $time, red, green, blue);
                end
                else
                begin
                    want = rgb_expected.pop_front();
                    check_channel("red", want.red, red);
                    check_channel("green", want.green, green);
                    check_channel("blue", want.blue, blue);
                end
                transfers_checked++;
            end
            @(posedge clk);
            if (took)
            begin
                if ($urandom_range(0, 79) == 0)
                    rx_burst = !rx_burst;
                stall_left = rx_burst ? 0 : $urandom_range(0, 17);
            end
            if (stall_left > 0)
            begin
                rgb_stall <= 1'b1;
                stall_left--;
            end
            else
                rgb_stall <= 1'b0;
        end
    end

    initial
    begin
        #6000000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        mismatches        = 0;
        pixels_sent       = 0;
        pixels_clipped    = 0;
        transfers_checked = 0;
        tx_burst          = 1'b0;
        rx_burst          = 1'b0;
        rst_n       <= 1'b0;
        pixel_valid <= 1'b0;
        hue         <= '0;
        saturation  <= '0;
        brightness  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (hsv_rows[i])
            send_pixel(hsv_rows[i].hue, hsv_rows[i].sat, hsv_rows[i].val,
                       hsv_rows[i].known, hsv_rows[i].rgb);
        drain_results();

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n == NUM_RANDOM / 2)
                drain_results();
            send_pixel(pick_hue(), pick_fraction(), pick_fraction(), 1'b0, '0);
        end
        pixel_valid <= 1'b0;

        wait (rgb_expected.size() == 0);
        repeat (12) @(posedge clk);
        $display("Sent %0d pixels (%0d with hue past 360 degrees), checked %0d transfers.",
                 pixels_sent, pixels_clipped, transfers_checked);
        $display("Found %0d mismatches.", mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* hsv_to_rgb_converter_top.f */
src/hsvrgb_pkg.sv
src/hsvrgb_prep.sv
src/hsvrgb_scale.sv
src/hsvrgb_route.sv
src/hsv_to_rgb_converter_top.sv
tb/tb_hsv_to_rgb_converter_top.sv
